FILE: rtl/core/sqlkt_pkg.sv
// Shared types, token codes and the keyword table for the SQL tokenizer.
// No dependencies; imported by every module of the block.
package sqlkt_pkg;

  localparam int KW_NUM    = 17;
  localparam int KW_MAXLEN = 9;

  typedef logic [KW_NUM-1:0] kw_mask_t;
  localparam kw_mask_t KW_ALL = '1;

  // Token kinds
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_NUMBER  = 5'd2;
  localparam logic [4:0] KIND_STRING  = 5'd3;
  localparam logic [4:0] KIND_STAR    = 5'd4;
  localparam logic [4:0] KIND_COMMA   = 5'd5;
  localparam logic [4:0] KIND_SEMI    = 5'd6;
  localparam logic [4:0] KIND_EQ      = 5'd7;
  localparam logic [4:0] KIND_LPAREN  = 5'd8;
  localparam logic [4:0] KIND_RPAREN  = 5'd9;
  localparam logic [4:0] KIND_GT      = 5'd10;
  localparam logic [4:0] KIND_GE      = 5'd11;
  localparam logic [4:0] KIND_LT      = 5'd12;
  localparam logic [4:0] KIND_LE      = 5'd13;
  localparam int         KIND_KW_BASE = 14;

  // Characters with a role of their own
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;

  // Keywords, right-justified: first character sits in the highest used byte.
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_NUM] = '{
    "select", "create", "table", "from", "use", "show", "databases",
    "tables", "insert", "where", "and", "or", "database", "varchar",
    "int", "double", "date"
  };
  localparam int KW_LEN [KW_NUM] = '{6, 6, 5, 4, 3, 4, 9, 6, 6, 5, 3, 2, 8, 7, 3, 6, 4};

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic        unrecognized;
    logic        last;
  } result_t;

  // Up to two results per input word, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  // Drop every keyword that has no character at idx or whose character at idx differs from c (case folded).
  function automatic kw_mask_t mask_update(input kw_mask_t m, input logic [15:0] idx,
                                           input logic [7:0] c);
    logic [7:0] lc;
    int         sh;
    kw_mask_t   r;
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    r  = m;
    for (int k = 0; k < KW_NUM; k++) begin
      if (idx >= 16'(KW_LEN[k])) begin
        r[k] = 1'b0;
      end else begin
        sh = 8 * (KW_LEN[k] - 1 - int'(idx[3:0]));
        if (KW_TEXT[k][sh +: 8] != lc) r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  // First surviving keyword of exactly this length, else identifier.
  function automatic logic [4:0] word_kind(input kw_mask_t m, input logic [15:0] len);
    logic [4:0] kd;
    kd = KIND_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (m[k] && len == 16'(KW_LEN[k])) kd = 5'(KIND_KW_BASE + k);
    end
    return kd;
  endfunction

endpackage

FILE: rtl/core/sqlkt_lexer.sv
// Lexer state and next-state logic: one byte per accepted word, up to two results.
// Depends on sqlkt_pkg.
module sqlkt_lexer #(
  parameter int POS_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         ch,
  output sqlkt_pkg::push_t   push
);
  import sqlkt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_WORD = 3'd1,
    M_NUM  = 3'd2,
    M_STR  = 3'd3,
    M_GT   = 3'd4,
    M_LT   = 3'd5
  } mode_t;

  mode_t                mode, mode_next;
  logic                 quote_is_double, quote_is_double_next;
  kw_mask_t             keyword_mask, keyword_mask_next;
  logic [15:0]          token_start, token_start_next;
  logic [15:0]          token_length, token_length_next;
  logic [POS_WIDTH-1:0] position, position_next;

  logic [POS_WIDTH-1:0] pos_inc;
  logic [15:0]          pos16;
  logic                 is_sp, is_al, is_dg;

  // fresh-token decode of ch
  mode_t       b_mode;
  logic        b_emit, b_set_start, b_set_len, b_set_qd, b_qd;
  logic [15:0] b_tstart, b_tlen;
  kw_mask_t    b_mask;
  result_t     b_res;

  logic        use_b, cv, bv;
  result_t     cres;

  assign pos_inc = position + POS_WIDTH'(1);
  assign pos16   = 16'(position);
  assign is_sp   = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0d);
  assign is_al   = (ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a);
  assign is_dg   = (ch >= 8'h30 && ch <= 8'h39);

  always_comb begin
    b_mode      = M_IDLE;
    b_emit      = 1'b0;
    b_set_start = 1'b0;
    b_set_len   = 1'b0;
    b_set_qd    = 1'b0;
    b_qd        = 1'b0;
    b_tstart    = pos16;
    b_tlen      = 16'd1;
    b_mask      = KW_ALL;
    b_res       = '0;
    b_res.start_res = pos16;
    if (is_sp) begin
      b_mode = M_IDLE;
    end else if (ch == CH_NUL) begin
      b_emit       = 1'b1;
      b_res.kind   = KIND_END;
    end else if (is_al) begin
      b_mode      = M_WORD;
      b_set_start = 1'b1;
      b_set_len   = 1'b1;
      b_mask      = mask_update(KW_ALL, 16'd0, ch);
    end else if (is_dg) begin
      b_mode      = M_NUM;
      b_set_start = 1'b1;
      b_set_len   = 1'b1;
    end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
      b_mode      = M_STR;
      b_set_start = 1'b1;
      b_set_len   = 1'b1;
      b_set_qd    = 1'b1;
      b_qd        = (ch == CH_DQUOTE);
      b_tstart    = 16'(pos_inc);   // string body starts after the quote
      b_tlen      = 16'd0;
    end else if (ch == CH_GT) begin
      b_mode      = M_GT;
      b_set_start = 1'b1;
    end else if (ch == CH_LT) begin
      b_mode      = M_LT;
      b_set_start = 1'b1;
    end else begin
      b_emit       = 1'b1;
      b_res.length = 16'd1;
      case (ch)
        CH_STAR:   b_res.kind = KIND_STAR;
        CH_COMMA:  b_res.kind = KIND_COMMA;
        CH_SEMI:   b_res.kind = KIND_SEMI;
        CH_EQ:     b_res.kind = KIND_EQ;
        CH_LPAREN: b_res.kind = KIND_LPAREN;
        CH_RPAREN: b_res.kind = KIND_RPAREN;
        default: begin
          b_res.kind         = KIND_END;
          b_res.length       = 16'd0;
          b_res.unrecognized = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    mode_next            = mode;
    quote_is_double_next = quote_is_double;
    keyword_mask_next    = keyword_mask;
    token_start_next     = token_start;
    token_length_next    = token_length;
    position_next        = (ch == CH_NUL) ? '0 : pos_inc;
    use_b                = 1'b0;
    cv                   = 1'b0;
    cres                 = '0;
    cres.start_res       = token_start;
    cres.length          = token_length;
    case (mode)
      M_WORD: begin
        if (is_al || is_dg || ch == CH_UNDER) begin
          keyword_mask_next = mask_update(keyword_mask, token_length, ch);
          token_length_next = sat_inc(token_length);
        end else begin
          cv        = 1'b1;
          cres.kind = word_kind(keyword_mask, token_length);
          use_b     = 1'b1;
        end
      end
      M_NUM: begin
        if (is_dg) begin
          token_length_next = sat_inc(token_length);
        end else begin
          cv        = 1'b1;
          cres.kind = KIND_NUMBER;
          use_b     = 1'b1;
        end
      end
      M_STR: begin
        if (ch == (quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
          cv        = 1'b1;
          cres.kind = KIND_STRING;
          mode_next = M_IDLE;
        end else if (ch == CH_NUL) begin
          // unterminated string closes at end of input
          cv        = 1'b1;
          cres.kind = KIND_STRING;
          use_b     = 1'b1;
        end else begin
          token_length_next = sat_inc(token_length);
        end
      end
      M_GT, M_LT: begin
        cv = 1'b1;
        if (ch == CH_EQ) begin
          cres.kind   = (mode == M_GT) ? KIND_GE : KIND_LE;
          cres.length = 16'd2;
          mode_next   = M_IDLE;
        end else begin
          cres.kind   = (mode == M_GT) ? KIND_GT : KIND_LT;
          cres.length = 16'd1;
          use_b       = 1'b1;
        end
      end
      default: use_b = 1'b1;
    endcase

    if (use_b) begin
      mode_next         = b_mode;
      keyword_mask_next = b_mask;
      if (b_set_start) token_start_next     = b_tstart;
      if (b_set_len)   token_length_next    = b_tlen;
      if (b_set_qd)    quote_is_double_next = b_qd;
    end
    bv = use_b & b_emit;

    push.count   = in_valid ? (2'(cv) + 2'(bv)) : 2'd0;
    push.r0      = cv ? cres : b_res;
    push.r0.last = !(cv && bv);
    push.r1      = b_res;
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= M_IDLE;
      quote_is_double <= 1'b0;
      keyword_mask    <= KW_ALL;
      token_start     <= '0;
      token_length    <= '0;
      position        <= '0;
    end else if (in_valid) begin
      mode            <= mode_next;
      quote_is_double <= quote_is_double_next;
      keyword_mask    <= keyword_mask_next;
      token_start     <= token_start_next;
      token_length    <= token_length_next;
      position        <= position_next;
    end
  end

endmodule

FILE: rtl/core/sqlkt_out_fifo.sv
// Four-entry result queue: takes up to two results a cycle, gives one while out_ready is high.
// Depends on sqlkt_pkg.
module sqlkt_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  sqlkt_pkg::push_t    push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output sqlkt_pkg::result_t  out_res
);
  import sqlkt_pkg::*;

  result_t    mem [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_res   = mem[rp];
  // two free slots needed: a byte may close one token and emit another
  assign room      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wp] <= push.r0;
    if (push.count == 2'd2) mem[wp + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.count;
      rp    <= rp + 2'(pop);
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule

FILE: rtl/core/sql_keyword_tokenizer_unit.sv
// SQL keyword tokenizer top level: byte stream in, token words out.
// A result word is written into the result queue on the edge that takes the byte that causes it.
// Throughput: one byte per cycle while the queue has room for two tokens; a byte
// that yields two tokens is still taken as a single byte, and the four-entry result
// queue drains one token per cycle while m_axis_tready is high. Reset: rst synchronous
// active high; lexer returns to idle, offset zero, queue empty. Depends on sqlkt_pkg, sqlkt_lexer, sqlkt_out_fifo.
module sql_keyword_tokenizer_unit #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] kind, [20:5] start_res, [36:21] length, zero fill
  output logic [0:0]  m_axis_tuser,   // [0] unrecognized
  output logic        m_axis_tlast    // last token caused by this input byte
);
  import sqlkt_pkg::*;

  push_t   push;
  result_t head;
  logic    room;
  logic    in_fire;

  // A byte is taken whenever the queue can absorb the worst case of two
  // tokens; the lexer state and offset advance on exactly those words.
  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid && room;

  sqlkt_lexer #(
    .POS_WIDTH (POS_WIDTH)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_fire),
    .ch       (s_axis_tdata),
    .push     (push)
  );

  // Queue parts the two sides: input keeps flowing while up to two tokens wait.
  sqlkt_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (head)
  );

  assign m_axis_tdata = {3'b000, head.length, head.start_res, head.kind};
  assign m_axis_tuser = head.unrecognized;
  assign m_axis_tlast = head.last;

endmodule
